// ----- design/ftcf_pkg.sv -----
// Shared constants and types for the time-count to calendar-field converter.
package ftcf_pkg;

  // Pipeline shape: four stages split the count into days and ticks of day,
  // then the time-of-day and date branches run side by side to the last stage.
  localparam int unsigned PipeDepth  = 15;
  localparam int unsigned BranchBase = 4;
  localparam int unsigned TimeStages = 9;

  // Widths between the day split and the two branches
  localparam int unsigned DaysW = 25;
  localparam int unsigned RemW  = 40;

  // One load enable per pipeline stage
  typedef logic [PipeDepth-1:0] stage_en_t;

  // Time-of-day result fields
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } tod_t;

  // Date result fields
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
  } cal_t;

endpackage

// ----- design/ftcf_pipe_ctrl.sv -----
// Valid bits and per-stage load enables of the converter pipeline.
module ftcf_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output ftcf_pkg::stage_en_t  en_o
);

  localparam int unsigned Depth = ftcf_pkg::PipeDepth;
  localparam ftcf_pkg::stage_en_t StageOnes = '1;

  ftcf_pkg::stage_en_t v_q, v_d, rdy;

  // A stage may load when it or any stage after it is empty, or the output drains
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      rdy[k] = out_ready_i || (|(~v_q & (StageOnes << k)));
    end
  end

  // Shift valid bits one stage on
  always_comb begin
    v_d = {v_q[Depth-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Depth; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign en_o        = rdy;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Depth-1];

`ifndef ASSERT_OFF
  // Items in flight change only by transfers at the two ends
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ($countones(v_q) == $past($countones(v_q))
                + $past(int'(in_valid_i && rdy[0]))
                - $past(int'(v_q[Depth-1] && out_ready_i))))
    else $error("pipeline lost or duplicated an item");

  // Never refuse input while a bubble sits anywhere in the pipeline
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q != StageOnes) |-> in_ready_o)
    else $error("input stalled although a stage is empty");

  // An accepted transfer lands in the first stage
  a_first_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted item missing from first stage");
`endif

endmodule

// ----- design/ftcf_day_split.sv -----
// Splits the tick count into whole days and ticks within the day.
module ftcf_day_split (
  input  logic                           clk_i,
  input  ftcf_pkg::stage_en_t            en_i,
  input  logic [63:0]                    time_count_i,
  output logic [ftcf_pkg::DaysW-1:0]     days_o,
  output logic [ftcf_pkg::RemW-1:0]      rem_o
);

  // Ticks per day is 2^14 times this odd factor
  localparam logic [25:0] DayDiv   = 26'd52734375;
  // floor(2^50 / DayDiv): the estimate falls short by at most one day
  localparam logic [24:0] DayRecip = 25'((64'd1 << 50) / 64'd52734375);

  logic [49:0] p_hi_d, p_lo_d, p_hi_q, p_lo_q;
  logic [40:0] tl1_q, tl2_q, tl3_q;
  logic [49:0] est_sum;
  logic [24:0] q_d, q2_q, q3_q;
  logic [26:0] qd_d, qd_q;
  logic [26:0] r;
  logic        over;
  logic [25:0] rem26;
  logic [24:0] days_d, days_q;
  logic [39:0] rem_d, rem_q;

  // Stage 1: partial products of the reciprocal multiply
  always_comb begin
    p_hi_d = 50'(time_count_i[63:39]) * 50'(DayRecip);
    p_lo_d = 50'(time_count_i[38:14]) * 50'(DayRecip);
  end

  // Stage 2: combine partial products into the day estimate
  always_comb begin
    est_sum = p_hi_q + {25'd0, p_lo_q[49:25]};
    q_d     = est_sum[49:25];
  end

  // Stage 3: low bits of estimate times divisor suffice for the remainder
  always_comb begin
    qd_d = 27'(q2_q) * 27'(DayDiv);
  end

  // Stage 4: correct the estimate by one compare and subtract
  always_comb begin
    r      = tl3_q[40:14] - qd_q;
    over   = (r >= 27'(DayDiv));
    days_d = q3_q + 25'(over);
    rem26  = over ? 26'(r - 27'(DayDiv)) : r[25:0];
    rem_d  = {rem26, tl3_q[13:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
      tl1_q  <= time_count_i[40:0];
    end
    if (en_i[1]) begin
      q2_q  <= q_d;
      tl2_q <= tl1_q;
    end
    if (en_i[2]) begin
      qd_q  <= qd_d;
      q3_q  <= q2_q;
      tl3_q <= tl2_q;
    end
    if (en_i[3]) begin
      days_q <= days_d;
      rem_q  <= rem_d;
    end
  end

  assign days_o = days_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/ftcf_time_split.sv -----
// Breaks ticks within the day into hour, minute, second and millisecond.
module ftcf_time_split (
  input  logic                          clk_i,
  input  ftcf_pkg::stage_en_t           en_i,
  input  logic [ftcf_pkg::RemW-1:0]     rem_i,
  output ftcf_pkg::tod_t                tod_o
);

  localparam int unsigned Base      = ftcf_pkg::BranchBase;
  localparam int unsigned PadBase   = Base + ftcf_pkg::TimeStages;
  localparam int unsigned PadStages = ftcf_pkg::PipeDepth - PadBase;

  // floor(2^36 / 625): estimate of milliseconds, short by at most one
  localparam logic [26:0] MsRecip   = 27'((64'd1 << 36) / 64'd625);
  localparam logic [10:0] MsDiv     = 11'd625;
  // Rounded-up reciprocals, exact over the ranges used
  localparam logic [27:0] SecRecip  = 28'(((64'd1 << 37) + 64'd999) / 64'd1000);
  localparam logic [17:0] MinRecip  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
  localparam logic [17:0] HourRecip = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [26:0] MsPerSec  = 27'd1000;
  localparam logic [16:0] SecPerMin = 17'd60;
  localparam logic [10:0] MinPerHr  = 11'd60;

  logic [35:0] v;
  logic [44:0] ph_d, pl_d, ph_q, pl_q, ms_sum;
  logic [10:0] vl1_q, vl2_q, vl3_q;
  logic [26:0] qe_d, qe_q, qe3_q;
  logic [10:0] mprod_d, mprod_q, mr;
  logic [26:0] msday_d, msday_q, msday5_q, msday6_q;
  logic [54:0] ps_d, ps_q;
  logic [16:0] sod_d, sod_q, sod7_q, sod8_q;
  logic [26:0] sprod_d, sprod_q;
  logic [9:0]  ms_d, ms_q, ms8_q;
  logic [34:0] pm_d, pm_q, phr_d, phr_q;
  logic [10:0] mod_d, mod_q;
  logic [16:0] mod60_d, mod60_q;
  logic [4:0]  hour_d, hour_q;
  logic [10:0] hour60_d, hour60_q;
  ftcf_pkg::tod_t tod_d, tod_q;
  ftcf_pkg::tod_t pad_q [PadStages];

  // Ticks over 10000 equal (ticks >> 4) over 625
  assign v = rem_i[39:4];

  always_comb begin
    // T1: split reciprocal multiply
    ph_d   = 45'(v[35:18]) * 45'(MsRecip);
    pl_d   = 45'(v[17:0])  * 45'(MsRecip);
    // T2: millisecond estimate
    ms_sum = ph_q + {18'd0, pl_q[44:18]};
    qe_d   = ms_sum[44:18];
    // T3: low bits of estimate times divisor
    mprod_d = qe_q[10:0] * MsDiv;
    // T4: correct by one
    mr      = vl3_q - mprod_q;
    msday_d = qe3_q + 27'(mr >= MsDiv);
    // T5: seconds of day by reciprocal
    ps_d    = 55'(msday_q) * 55'(SecRecip);
    // T6: seconds and their millisecond count
    sod_d   = ps_q[53:37];
    sprod_d = 27'(sod_d) * MsPerSec;
    // T7: milliseconds, minutes and hours of day
    ms_d    = 10'(msday6_q - sprod_q);
    pm_d    = 35'(sod_q) * 35'(MinRecip);
    phr_d   = 35'(sod_q) * 35'(HourRecip);
    // T8: quotients and their back products
    mod_d    = pm_q[33:23];
    mod60_d  = 17'(mod_d) * SecPerMin;
    hour_d   = phr_q[33:29];
    hour60_d = 11'(hour_d) * MinPerHr;
    // T9: remainders give second and minute
    tod_d.hour        = hour_q;
    tod_d.minute      = 6'(mod_q - hour60_q);
    tod_d.second      = 6'(sod8_q - mod60_q);
    tod_d.millisecond = ms8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[Base]) begin
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      vl1_q <= v[10:0];
    end
    if (en_i[Base+1]) begin
      qe_q  <= qe_d;
      vl2_q <= vl1_q;
    end
    if (en_i[Base+2]) begin
      mprod_q <= mprod_d;
      qe3_q   <= qe_q;
      vl3_q   <= vl2_q;
    end
    if (en_i[Base+3]) begin
      msday_q <= msday_d;
    end
    if (en_i[Base+4]) begin
      ps_q     <= ps_d;
      msday5_q <= msday_q;
    end
    if (en_i[Base+5]) begin
      sod_q    <= sod_d;
      sprod_q  <= sprod_d;
      msday6_q <= msday5_q;
    end
    if (en_i[Base+6]) begin
      ms_q   <= ms_d;
      pm_q   <= pm_d;
      phr_q  <= phr_d;
      sod7_q <= sod_q;
    end
    if (en_i[Base+7]) begin
      mod_q    <= mod_d;
      mod60_q  <= mod60_d;
      hour_q   <= hour_d;
      hour60_q <= hour60_d;
      ms8_q    <= ms_q;
      sod8_q   <= sod7_q;
    end
    if (en_i[Base+8]) begin
      tod_q <= tod_d;
    end
    // Hold the result until the date branch catches up
    for (int k = 0; k < PadStages; k++) begin
      if (en_i[PadBase+k]) begin
        pad_q[k] <= (k == 0) ? tod_q : pad_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign tod_o = pad_q[PadStages-1];

endmodule

// ----- design/ftcf_date_split.sv -----
// Breaks a day number since 1601-01-01 into year, month, day and weekday.
module ftcf_date_split (
  input  logic                          clk_i,
  input  ftcf_pkg::stage_en_t           en_i,
  input  logic [ftcf_pkg::DaysW-1:0]    days_i,
  output ftcf_pkg::cal_t                cal_o
);

  localparam int unsigned Base = ftcf_pkg::BranchBase;

  // Days from 0000-03-01 to 1601-01-01
  localparam logic [24:0] MarchShift  = 25'd584694;
  localparam logic [24:0] DaysPerEra  = 25'd146097;
  localparam logic [15:0] YearsPerEra = 16'd400;
  localparam logic [16:0] DaysPerYear = 17'd365;
  // Rounded-up reciprocals, exact over the ranges used
  localparam logic [25:0] EraRecip  = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [18:0] QuadRecip = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] YearRecip = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [17:0] Cent1 = 18'd36524;
  localparam logic [17:0] Cent2 = 18'd73048;
  localparam logic [17:0] Cent3 = 18'd109572;
  localparam logic [17:0] Cent4 = 18'd146096;
  localparam logic [3:0]  LastMonth = 4'd11;
  localparam logic [3:0]  JanIdx    = 4'd10;

  // First day of each month, counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  logic [24:0] z_d, z_q, z2_q, z3_q, dp1_d, dp1_q;
  logic [26:0] dp1_ext;
  logic [5:0]  s1_lo, s1_hi, s1_d, s1_q;
  logic [3:0]  s2_d, s2_q;
  logic [2:0]  wd_d, wd_q, wd5_q, wd6_q, wd7_q, wd8_q, wd9_q, wd10_q;
  logic [50:0] pe_d, pe_q;
  logic [7:0]  era;
  logic [24:0] eprod_d, eprod_q;
  logic [15:0] era400_d, era400_q, era5_q, era6_q, era7_q, era8_q;
  logic [17:0] doe_d, doe_q, doe5_q, doe6_q, doe7_q, doe8_q;
  logic [36:0] p1460_d, p1460_q, p365_d, p365_q;
  logic [2:0]  c36_d, c36_q;
  logic        c146_d, c146_q;
  logic [17:0] a_d, a_q;
  logic [8:0]  yoe;
  logic [1:0]  c100;
  logic [16:0] t365_d, t365_q;
  logic [6:0]  yq_d, yq_q;
  logic [15:0] y0_d, y0_q, y0_9_q, y0_10_q;
  logic [8:0]  doy_d, doy_q, doy10_q;
  logic [3:0]  mp_d, mp_q;
  ftcf_pkg::cal_t cal_d, cal_q;

  always_comb begin
    // D1: shift origin to 0000-03-01, and weekday base
    z_d   = days_i + MarchShift;
    dp1_d = days_i + 25'd1;
    // D2: era by reciprocal; octal digit sum for modulo seven
    pe_d    = 51'(z_q) * 51'(EraRecip);
    dp1_ext = {2'b00, dp1_q};
    s1_lo   = '0;
    s1_hi   = '0;
    for (int i = 0; i < 5; i++) begin
      s1_lo = s1_lo + 6'(dp1_ext[3*i +: 3]);
    end
    for (int i = 5; i < 9; i++) begin
      s1_hi = s1_hi + 6'(dp1_ext[3*i +: 3]);
    end
    s1_d = s1_lo + s1_hi;
    // D3: era back products; fold digit sum again
    era      = pe_q[50:43];
    eprod_d  = 25'(era) * DaysPerEra;
    era400_d = 16'(era) * YearsPerEra;
    s2_d     = 4'(s1_q[5:3]) + 4'(s1_q[2:0]);
    // D4: day of era; final weekday reduction
    doe_d = 18'(z3_q - eprod_q);
    if (s2_q >= 4'd14) begin
      wd_d = 3'(s2_q - 4'd14);
    end else if (s2_q >= 4'd7) begin
      wd_d = 3'(s2_q - 4'd7);
    end else begin
      wd_d = s2_q[2:0];
    end
    // D5: leap-cycle counts within the era
    p1460_d = 37'(doe_q) * 37'(QuadRecip);
    c36_d   = 3'(doe_q >= Cent1) + 3'(doe_q >= Cent2) + 3'(doe_q >= Cent3)
            + 3'(doe_q >= Cent4);
    c146_d  = (doe_q >= Cent4);
    // D6: days with leap days taken out
    a_d = doe5_q - 18'(p1460_q[35:29]) + 18'(c36_q) - 18'(c146_q);
    // D7: year of era by reciprocal
    p365_d = 37'(a_q) * 37'(YearRecip);
    // D8: year start in days, and base year
    yoe    = p365_q[35:27];
    c100   = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    t365_d = 17'(yoe) * DaysPerYear;
    yq_d   = 7'(yoe[8:2]) - 7'(c100);
    y0_d   = era8_q + 16'(yoe);
    // D9: day of year from March
    doy_d = 9'(doe8_q - 18'(t365_q) - 18'(yq_q));
    // D10: month from March by threshold search
    mp_d = '0;
    for (int i = 1; i <= 11; i++) begin
      if (doy_q >= month_start(4'(i))) begin
        mp_d = 4'(i);
      end
    end
    // D11: calendar fields; January and February belong to the next year
    cal_d.day     = 5'(doy10_q - month_start(mp_q) + 9'd1);
    cal_d.month   = (mp_q < JanIdx) ? mp_q + 4'd3 : mp_q - 4'd9;
    cal_d.year    = y0_10_q + 16'(mp_q >= JanIdx && mp_q <= LastMonth);
    cal_d.weekday = wd10_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[Base]) begin
      z_q   <= z_d;
      dp1_q <= dp1_d;
    end
    if (en_i[Base+1]) begin
      pe_q <= pe_d;
      z2_q <= z_q;
      s1_q <= s1_d;
    end
    if (en_i[Base+2]) begin
      eprod_q  <= eprod_d;
      era400_q <= era400_d;
      z3_q     <= z2_q;
      s2_q     <= s2_d;
    end
    if (en_i[Base+3]) begin
      doe_q  <= doe_d;
      wd_q   <= wd_d;
      era5_q <= era400_q;
    end
    if (en_i[Base+4]) begin
      p1460_q <= p1460_d;
      c36_q   <= c36_d;
      c146_q  <= c146_d;
      doe5_q  <= doe_q;
      era6_q  <= era5_q;
      wd5_q   <= wd_q;
    end
    if (en_i[Base+5]) begin
      a_q    <= a_d;
      doe6_q <= doe5_q;
      era7_q <= era6_q;
      wd6_q  <= wd5_q;
    end
    if (en_i[Base+6]) begin
      p365_q <= p365_d;
      doe7_q <= doe6_q;
      era8_q <= era7_q;
      wd7_q  <= wd6_q;
    end
    if (en_i[Base+7]) begin
      t365_q <= t365_d;
      yq_q   <= yq_d;
      y0_q   <= y0_d;
      doe8_q <= doe7_q;
      wd8_q  <= wd7_q;
    end
    if (en_i[Base+8]) begin
      doy_q  <= doy_d;
      y0_9_q <= y0_q;
      wd9_q  <= wd8_q;
    end
    if (en_i[Base+9]) begin
      mp_q    <= mp_d;
      doy10_q <= doy_q;
      y0_10_q <= y0_9_q;
      wd10_q  <= wd9_q;
    end
    if (en_i[Base+10]) begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

// ----- design/filetime_to_calendar_fields.sv -----
// Top level: 100 ns tick count since 1601 to UTC calendar fields, fully pipelined.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  -------------------------------------------
//  input    in_valid_i / in_ready_o  time_count_i
//  output   out_valid_o/ out_ready_i year_o month_o day_o hour_o minute_o
//                                    second_o millisecond_o weekday_o
//
//  One item enters per cycle unless the pipeline is full and the output stalled; each
//  result passes through 15 register stages, a depth set by the date branch (era,
//  leap-cycle and month steps).
//  Reset clears only the valid bits; no clearing pass is needed.
//  A stalled output holds the last stage; earlier stages keep filling bubbles,
//  so input is refused only when every stage holds an item.
module filetime_to_calendar_fields (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] time_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o,
  output logic [2:0]  weekday_o
);

  ftcf_pkg::stage_en_t             stage_en;
  logic [ftcf_pkg::DaysW-1:0]      days;
  logic [ftcf_pkg::RemW-1:0]       rem;
  ftcf_pkg::tod_t                  tod;
  ftcf_pkg::cal_t                  cal;

  // Valid tracking and stage enables
  ftcf_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .en_o        (stage_en)
  );

  // Days and ticks within the day
  ftcf_day_split u_day (
    .clk_i        (clk_i),
    .en_i         (stage_en),
    .time_count_i (time_count_i),
    .days_o       (days),
    .rem_o        (rem)
  );

  // Time-of-day branch
  ftcf_time_split u_time (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .rem_i (rem),
    .tod_o (tod)
  );

  // Date branch
  ftcf_date_split u_date (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .days_i (days),
    .cal_o  (cal)
  );

  assign year_o        = cal.year;
  assign month_o       = cal.month;
  assign day_o         = cal.day;
  assign weekday_o     = cal.weekday;
  assign hour_o        = tod.hour;
  assign minute_o      = tod.minute;
  assign second_o      = tod.second;
  assign millisecond_o = tod.millisecond;

`ifndef ASSERT_OFF
  // Date fields of a presented result stay in their ranges
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1
                     && weekday_o <= 3'd6 && year_o >= 16'd1601))
    else $error("date field out of range");

  // Time fields of a presented result stay in their ranges
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59
                     && millisecond_o <= 10'd999))
    else $error("time field out of range");
`endif

endmodule

// ----- sim/tb_filetime_to_calendar_fields.sv -----
// Self-checking testbench for the tick-count to UTC calendar-field converter.
module tb_filetime_to_calendar_fields;

  localparam logic [63:0] TicksPerDay    = 64'd864000000000;
  localparam logic [63:0] UnixEpochTicks = 64'd116444736000000000;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned ItemsPerPhase  = 330;

  // One broken-down instant, date fields then time-of-day fields
  typedef struct packed {
    ftcf_pkg::cal_t date;
    ftcf_pkg::tod_t tod;
  } calendar_fields_t;

  // Hold the expected calendar fields in transfer order and check results against them
  class calendar_scoreboard;
    calendar_fields_t pending_dates[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Floor-divide the tick count into date and time of day
    function calendar_fields_t break_down(logic [63:0] ticks);
      calendar_fields_t fields;
      longint unsigned  ms_total, secs, days, sec_of_day;
      longint unsigned  shifted, era, day_of_era, year_of_era, day_of_year;
      longint unsigned  month_idx, mday, mon, yr;
      ms_total    = ticks / 64'd10000;
      secs        = ms_total / 1000;
      days        = secs / 86400;
      sec_of_day  = secs % 86400;
      // Count days from 0000-03-01 so that leap days fall at the end of a year
      shifted     = days + 584694;
      era         = shifted / 146097;
      day_of_era  = shifted - era * 146097;
      year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                     - day_of_era / 146096) / 365;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
      month_idx   = (5 * day_of_year + 2) / 153;
      mday        = day_of_year - (153 * month_idx + 2) / 5 + 1;
      mon         = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
      yr          = year_of_era + era * 400 + ((mon <= 2) ? 1 : 0);
      fields.date.year        = 16'(yr);
      fields.date.month       = 4'(mon);
      fields.date.day         = 5'(mday);
      // 1601-01-01 was a Monday
      fields.date.weekday     = 3'((days + 1) % 7);
      fields.tod.hour         = 5'(sec_of_day / 3600);
      fields.tod.minute       = 6'((sec_of_day / 60) % 60);
      fields.tod.second       = 6'(sec_of_day % 60);
      fields.tod.millisecond  = 10'(ms_total % 1000);
      return fields;
    endfunction

    function void note_count(logic [63:0] ticks);
      pending_dates.push_back(break_down(ticks));
    endfunction

    function void match_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(calendar_fields_t got);
      calendar_fields_t want;
      if (pending_dates.size() == 0) begin
        $error("result transfer with no time count outstanding");
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      match_field("year", want.date.year, got.date.year);
      match_field("month", want.date.month, got.date.month);
      match_field("day", want.date.day, got.date.day);
      match_field("weekday", want.date.weekday, got.date.weekday);
      match_field("hour", want.tod.hour, got.tod.hour);
      match_field("minute", want.tod.minute, got.tod.minute);
      match_field("second", want.tod.second, got.tod.second);
      match_field("millisecond", want.tod.millisecond, got.tod.millisecond);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] time_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [9:0]  millisecond_o;
  logic [2:0]  weekday_o;

  calendar_scoreboard sb;
  int unsigned        feed_idle_pct;
  int unsigned        drain_idle_pct;
  int unsigned        hold_cycles_left;
  int unsigned        cycle_count;

  filetime_to_calendar_fields dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .time_count_i  (time_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o),
    .millisecond_o (millisecond_o),
    .weekday_o     (weekday_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** filetime_to_calendar_fields: FAILED **");
      $finish;
    end
  end

  // Check each result transfer, then pick next ready; a long hold-off overrides the idling
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result({year_o, month_o, day_o, weekday_o,
                       hour_o, minute_o, second_o, millisecond_o});
    end
    if (hold_cycles_left > 0) begin
      out_ready_i      <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= drain_idle_pct);
    end
  end

  // Offer one time count after a random gap and hold it until the transfer
  task automatic feed_count(input logic [63:0] ticks);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    time_count_i <= ticks;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_count(ticks);
  endtask

  // Mix full-range counts, day boundaries, the common era and the top of the range
  function automatic logic [63:0] random_count();
    logic [63:0] offset;
    offset = {$urandom, $urandom} % TicksPerDay;
    case ($urandom_range(4))
      0, 1:    return {$urandom, $urandom};
      2: begin
        case ($urandom_range(2))
          0:       return 64'($urandom_range(21350397)) * TicksPerDay;
          1:       return 64'($urandom_range(21350397)) * TicksPerDay + TicksPerDay - 1;
          default: return 64'($urandom_range(21350397)) * TicksPerDay + offset;
        endcase
      end
      3:       return 64'($urandom_range(292000)) * TicksPerDay + offset;
      default: return 64'hFFFF_FFFF_FFFF_FFFF - ({$urandom, $urandom} % (TicksPerDay * 1000));
    endcase
  endfunction

  initial begin
    logic [63:0] corner_counts[$];
    sb               = new();
    cycle_count      = 0;
    hold_cycles_left = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    time_count_i    <= '0;
    out_ready_i     <= 1'b0;
    feed_idle_pct    = 34;
    drain_idle_pct  <= 73;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: origin, sub-millisecond ticks, day and year edges, the Unix epoch,
    // a non-leap century, a leap day, bit patterns and the largest count
    corner_counts = '{64'd0, 64'd9999, 64'd10000, 64'd9999999,
                      TicksPerDay - 1, TicksPerDay,
                      TicksPerDay * 365 - 1, TicksPerDay * 365,
                      UnixEpochTicks - 10000, UnixEpochTicks - 1, UnixEpochTicks,
                      TicksPerDay * 36217 + TicksPerDay - 1, TicksPerDay * 36218,
                      TicksPerDay * 145790 + 64'd432000000000, TicksPerDay * 145791 - 1,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                      64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
                      64'hFFFF_FFFF_FFFF_FFFF - TicksPerDay, 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (corner_counts[i]) feed_count(corner_counts[i]);

    // Random: slow receiver, then slow sender
    repeat (ItemsPerPhase) feed_count(random_count());
    feed_idle_pct   = 73;
    drain_idle_pct <= 34;
    repeat (ItemsPerPhase) feed_count(random_count());

    // Full rate, opened by a long receiver hold-off so the pipeline fills and stalls
    feed_idle_pct     = 0;
    drain_idle_pct   <= 0;
    hold_cycles_left <= 4 * ftcf_pkg::PipeDepth;
    repeat (ItemsPerPhase) feed_count(random_count());
    in_valid_i <= 1'b0;

    // Drain, then allow a pipeline's worth of cycles for stray results
    while (sb.pending_dates.size() != 0) @(posedge clk_i);
    repeat (ftcf_pkg::PipeDepth + 5) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("** filetime_to_calendar_fields: PASSED **");
    end else begin
      $display("** filetime_to_calendar_fields: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filetime_to_calendar_fields.f -----
design/ftcf_pkg.sv
design/ftcf_pipe_ctrl.sv
design/ftcf_day_split.sv
design/ftcf_time_split.sv
design/ftcf_date_split.sv
design/filetime_to_calendar_fields.sv
sim/tb_filetime_to_calendar_fields.sv
